// File: src/krrn_pkg.sv
// ----------------------------------------------------------------------------
// krrn_pkg
// types, constants and fixed-point helpers shared by the radial root finder
// ----------------------------------------------------------------------------
package krrn_pkg;

    localparam int FRAC_BITS      = 24;
    localparam int MAX_ITERATIONS = 32;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int VAL_W          = 64;

    localparam logic signed [VAL_W-1:0] SAT_LIM = 64'sd1 <<< 62;
    localparam logic signed [VAL_W:0]   SAT_LIM_W = 65'sd1 <<< 62;
    localparam logic signed [VAL_W-1:0] RLIM_RAW = 64'sd64 <<< FRAC_BITS;
    localparam logic signed [VAL_W-1:0] RLIM =
        (RLIM_RAW > 64'sd2147483647) ? 64'sd2147483647 : RLIM_RAW;

    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_CAP       = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DER  = 2'd2;

    localparam logic CFG_SPIN      = 1'b0;
    localparam logic CFG_TOLERANCE = 1'b1;

    typedef struct packed {
        logic signed [31:0] impact_b;
        logic signed [35:0] carter_q;
        logic        [30:0] start_radius;
    } krrn_in_t;

    typedef struct packed {
        logic signed [31:0] root_radius;
        logic        [1:0]  status;
    } krrn_out_t;

    // datapath micro-operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV
    } krrn_op_t;

    // register file addresses
    typedef enum logic [3:0] {
        RG_A, RG_B, RG_Q, RG_R, RG_A2, RG_AB, RG_D, RG_E,
        RG_R2, RG_RV, RG_RP, RG_T, RG_U, RG_STEP, RG_ZERO, RG_SP
    } krrn_rg_t;

    typedef struct packed {
        krrn_op_t op;
        krrn_rg_t src_x;
        krrn_rg_t src_y;
        krrn_rg_t dst;
        logic     load;
        logic     update_r;
    } krrn_cmd_t;

    typedef struct packed {
        logic busy;
        logic rp_zero;
        logic converged;
    } krrn_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_CHECK,
        ST_DONE
    } krrn_state_t;

    function automatic logic signed [VAL_W-1:0] clamp62(input logic signed [VAL_W:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > SAT_LIM_W)
            r = SAT_LIM;
        else if (x < -SAT_LIM_W)
            r = -SAT_LIM;
        else
            r = x[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] sadd(input logic signed [VAL_W-1:0] x,
                                                     input logic signed [VAL_W-1:0] y);
        logic signed [VAL_W:0] s;
        s = {x[VAL_W-1], x} + {y[VAL_W-1], y};
        return clamp62(s);
    endfunction

endpackage

// File: src/kerr_radial_root_newton.sv
// ----------------------------------------------------------------------------
// kerr_radial_root_newton
// newton-raphson root of the kerr radial quartic, signed q.24 fixed point
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  krrn_in_t
// out      output     out_valid/out_stall krrn_out_t
// cfg      input      cfg_we             cfg_index, cfg_data
//
// an iteration runs thirteen multiplies on the shared multiplier, a divide
// (128 radix-2 steps), 24 add and subtract steps and a convergence check;
// an item runs a setup sequence plus up to 32 iterations before the result
// is offered. one item is in flight at a time.
// reset clears the controller and the configuration to spin 0, tolerance 1677.
// out_stall holds the result in place; in_stall is high while an item is busy.
module kerr_radial_root_newton
    import krrn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  krrn_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output krrn_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [25:0] cfg_data
);

    logic signed [25:0] spin_reg;
    logic [24:0]        tol_reg;
    krrn_cmd_t          cmd;
    logic               cmd_valid;
    krrn_stat_t         stat;
    logic               capture;
    logic [1:0]         status;
    logic signed [31:0] radius;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg <= '0;
            tol_reg  <= 25'd1677;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPIN:      spin_reg <= cfg_data;
                CFG_TOLERANCE: tol_reg  <= cfg_data[24:0];
                default:       spin_reg <= spin_reg;
            endcase
        end
    end

    krrn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .capture   (capture),
        .status    (status)
    );

    krrn_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid && (capture || !cmd.load)),
        .in_item   (in_data),
        .spin_val  (spin_reg),
        .tol_val   (tol_reg),
        .stat      (stat),
        .radius    (radius)
    );

    assign out_data.root_radius = radius;
    assign out_data.status      = status;

endmodule

// File: src/krrn_mul.sv
// ----------------------------------------------------------------------------
// krrn_mul
// multi-cycle saturating fixed-point multiplier, floor rounding, 32x32 partials
// ----------------------------------------------------------------------------
module krrn_mul
    import krrn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] x,
    input  logic signed [VAL_W-1:0] y,
    output logic                    done,
    output logic signed [VAL_W-1:0] p
);

    logic [2:0]              cnt_reg, cnt_next;
    logic [62:0]             mx_reg, my_reg;
    logic                    neg_reg;
    logic [127:0]            acc_reg;
    logic [63:0]             pp_reg;
    logic [6:0]              sh_reg;
    logic signed [VAL_W-1:0] p_reg;
    logic                    done_reg;
    logic [62:0]             mx_in, my_in;
    logic [31:0]             op_x, op_y;
    logic [127:0]            q_full;
    logic [127:0]            q_sh;
    logic [VAL_W-1:0]        qmag;
    logic                    rem_nz;

    always_comb
    begin
        mx_in = x[VAL_W-1] ? 63'(-x) : x[62:0];
        my_in = y[VAL_W-1] ? 63'(-y) : y[62:0];
        op_x  = cnt_reg[1] ? {1'b0, mx_reg[62:32]} : mx_reg[31:0];
        op_y  = cnt_reg[0] ? {1'b0, my_reg[62:32]} : my_reg[31:0];
        cnt_next = cnt_reg;
        if (start)
            cnt_next = 3'd1;
        else if (cnt_reg != 3'd0)
            cnt_next = (cnt_reg == 3'd6) ? 3'd0 : cnt_reg + 3'd1;
    end

    always_comb
    begin
        q_full = acc_reg;
        q_sh   = q_full >> FRAC_BITS;
        rem_nz = |q_full[FRAC_BITS-1:0];
        qmag   = q_sh[VAL_W-1:0] + {63'd0, neg_reg & rem_nz};
        if (|q_sh[127:VAL_W] || qmag > 64'(SAT_LIM))
            qmag = 64'(SAT_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= (cnt_reg == 3'd6);
        end
    end

    // cnt_reg values 1..4 form partial products, 2..5 accumulate, 6 rounds
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mx_reg  <= (x == -x && x[VAL_W-1]) ? 63'(SAT_LIM) : mx_in;
            my_reg  <= (y == -y && y[VAL_W-1]) ? 63'(SAT_LIM) : my_in;
            neg_reg <= x[VAL_W-1] ^ y[VAL_W-1];
            acc_reg <= '0;
        end
        else
        begin
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                pp_reg <= op_x * op_y;
                sh_reg <= {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0], 5'd0};
            end
            if (cnt_reg >= 3'd2 && cnt_reg <= 3'd5)
                acc_reg <= acc_reg + ({64'd0, pp_reg} << sh_reg);
            if (cnt_reg == 3'd6)
                p_reg <= neg_reg ? -$signed(qmag) : $signed(qmag);
        end
    end

    always_comb
    begin
        done = done_reg;
        p    = p_reg;
    end

endmodule

// File: src/krrn_div.sv
// ----------------------------------------------------------------------------
// krrn_div
// radix-2 restoring divider, (n << FRAC_BITS) / d, truncated, saturating
// ----------------------------------------------------------------------------
module krrn_div
    import krrn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] n,
    input  logic signed [VAL_W-1:0] d,
    output logic                    done,
    output logic signed [VAL_W-1:0] q
);

    logic [7:0]       cnt_reg;
    logic             run_reg;
    logic [127:0]     num_reg;
    logic [VAL_W:0]   rem_reg;
    logic [VAL_W-1:0] den_reg;
    logic [VAL_W-1:0] quo_reg;
    logic             sat_reg;
    logic             neg_reg;
    logic             done_reg;
    logic [VAL_W-1:0] mn, md;
    logic [VAL_W:0]   rem_sh;
    logic             ge;
    logic [VAL_W-1:0] quo_nx;

    always_comb
    begin
        mn     = 64'(sadd(n, 64'sd0) < 0 ? -sadd(n, 64'sd0) : sadd(n, 64'sd0));
        md     = 64'(sadd(d, 64'sd0) < 0 ? -sadd(d, 64'sd0) : sadd(d, 64'sd0));
        rem_sh = {rem_reg[VAL_W-1:0], num_reg[127]};
        ge     = rem_sh >= {1'b0, den_reg};
        quo_nx = sat_reg ? quo_reg : {quo_reg[VAL_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 8'd127;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {64'd0, mn} << FRAC_BITS;
            den_reg <= md;
            rem_reg <= '0;
            quo_reg <= '0;
            sat_reg <= 1'b0;
            neg_reg <= n[VAL_W-1] ^ d[VAL_W-1];
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            if (!sat_reg && quo_nx > 64'(SAT_LIM))
            begin
                sat_reg <= 1'b1;
                quo_reg <= 64'(SAT_LIM);
            end
            else
                quo_reg <= quo_nx;
        end
    end

    always_comb
    begin
        done = done_reg;
        q    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

endmodule

// File: src/krrn_datapath.sv
// ----------------------------------------------------------------------------
// krrn_datapath
// register file, multiplier, divider and saturating adder driven by commands
// ----------------------------------------------------------------------------
module krrn_datapath
    import krrn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  krrn_cmd_t               cmd,
    input  logic                    cmd_valid,
    input  krrn_in_t                in_item,
    input  logic signed [25:0]      spin_val,
    input  logic [24:0]             tol_val,
    output krrn_stat_t              stat,
    output logic signed [31:0]      radius
);

    logic signed [VAL_W-1:0] rf_reg [16];
    logic signed [VAL_W-1:0] x, y, sum;
    logic                    mul_start, div_start, mul_done, div_done;
    logic signed [VAL_W-1:0] mul_p, div_q;
    logic                    busy_reg;
    logic signed [VAL_W-1:0] rnew;
    logic [VAL_W-1:0]        smag;
    logic signed [VAL_W-1:0] r_in;

    always_comb
    begin
        x         = rf_reg[cmd.src_x];
        y         = rf_reg[cmd.src_y];
        mul_start = cmd_valid && cmd.op == OP_MUL;
        div_start = cmd_valid && cmd.op == OP_DIV;
        sum       = (cmd.op == OP_SUB) ? sadd(x, -y) : sadd(x, y);
        rnew      = rf_reg[RG_R] - rf_reg[RG_STEP];
        if (rnew > RLIM)
            rnew = RLIM;
        else if (rnew < -RLIM)
            rnew = -RLIM;
        smag = 64'(rf_reg[RG_STEP] < 0 ? -rf_reg[RG_STEP] : rf_reg[RG_STEP]);
        r_in = $signed({33'd0, in_item.start_radius});
        if (r_in > RLIM)
            r_in = RLIM;
    end

    krrn_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (x),
        .y     (y),
        .done  (mul_done),
        .p     (mul_p)
    );

    krrn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (x),
        .d     (y),
        .done  (div_done),
        .q     (div_q)
    );

    krrn_rg_t dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (mul_start || div_start)
            busy_reg <= 1'b1;
        else if (mul_done || div_done)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        rf_reg[RG_ZERO] <= '0;
        if (cmd_valid && cmd.load)
        begin
            rf_reg[RG_A] <= 64'(spin_val);
            rf_reg[RG_B] <= 64'(in_item.impact_b);
            rf_reg[RG_Q] <= 64'(in_item.carter_q);
            rf_reg[RG_R] <= r_in;
        end
        else if (cmd_valid && cmd.update_r)
            rf_reg[RG_R] <= rnew;
        else if (cmd_valid && (cmd.op == OP_ADD || cmd.op == OP_SUB))
            rf_reg[cmd.dst] <= sum;
        if (mul_start || div_start)
            dst_reg <= cmd.dst;
        if (mul_done)
            rf_reg[dst_reg] <= mul_p;
        if (div_done)
            rf_reg[dst_reg] <= div_q;
    end

    always_comb
    begin
        stat.busy      = busy_reg;
        stat.rp_zero   = rf_reg[RG_RP] == '0;
        stat.converged = smag <= {39'd0, tol_val};
        radius         = rf_reg[RG_R][31:0];
    end

endmodule

// File: src/krrn_ctrl.sv
// ----------------------------------------------------------------------------
// krrn_ctrl
// sequencer stepping through the micro-program of one newton iteration
// ----------------------------------------------------------------------------
module krrn_ctrl
    import krrn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  krrn_stat_t  stat,
    output krrn_cmd_t   cmd,
    output logic        cmd_valid,
    output logic        capture,
    output logic [1:0]  status
);

    localparam int PROG_LEN = 44;
    localparam int PC_W     = $clog2(PROG_LEN);
    localparam int SETUP    = 6;
    localparam int DERIV_END = 43;

    krrn_state_t       state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic [1:0]        status_reg, status_next;
    logic              wait_reg;
    krrn_cmd_t         prog;

    function automatic krrn_cmd_t mk(input krrn_op_t o, input krrn_rg_t a,
                                     input krrn_rg_t b, input krrn_rg_t d);
        krrn_cmd_t c;
        c.op = o; c.src_x = a; c.src_y = b; c.dst = d;
        c.load = 1'b0; c.update_r = 1'b0;
        return c;
    endfunction

    // micro-program: setup, value of R, derivative, divide
    always_comb
    begin
        prog = mk(OP_NONE, RG_ZERO, RG_ZERO, RG_ZERO);
        case (pc_reg)
            6'd0:  prog = mk(OP_MUL, RG_A, RG_A, RG_A2);
            6'd1:  prog = mk(OP_MUL, RG_A, RG_B, RG_AB);
            6'd2:  prog = mk(OP_SUB, RG_B, RG_A, RG_D);
            6'd3:  prog = mk(OP_MUL, RG_D, RG_D, RG_E);
            6'd4:  prog = mk(OP_ADD, RG_E, RG_Q, RG_E);
            6'd5:  prog = mk(OP_NONE, RG_ZERO, RG_ZERO, RG_ZERO);
            6'd6:  prog = mk(OP_MUL, RG_R, RG_R, RG_R2);
            6'd7:  prog = mk(OP_MUL, RG_R2, RG_R2, RG_RV);
            6'd8:  prog = mk(OP_MUL, RG_A2, RG_A2, RG_T);
            6'd9:  prog = mk(OP_ADD, RG_RV, RG_T, RG_RV);
            6'd10: prog = mk(OP_MUL, RG_AB, RG_AB, RG_T);
            6'd11: prog = mk(OP_ADD, RG_RV, RG_T, RG_RV);
            6'd12: prog = mk(OP_MUL, RG_R2, RG_A2, RG_T);
            6'd13: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd14: prog = mk(OP_ADD, RG_RV, RG_T, RG_RV);
            6'd15: prog = mk(OP_MUL, RG_R2, RG_AB, RG_T);
            6'd16: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd17: prog = mk(OP_SUB, RG_RV, RG_T, RG_RV);
            6'd18: prog = mk(OP_MUL, RG_A2, RG_AB, RG_T);
            6'd19: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd20: prog = mk(OP_SUB, RG_RV, RG_T, RG_RV);
            6'd21: prog = mk(OP_MUL, RG_R2, RG_E, RG_T);
            6'd22: prog = mk(OP_SUB, RG_RV, RG_T, RG_RV);
            6'd23: prog = mk(OP_MUL, RG_R, RG_E, RG_U);
            6'd24: prog = mk(OP_ADD, RG_U, RG_U, RG_T);
            6'd25: prog = mk(OP_ADD, RG_RV, RG_T, RG_RV);
            6'd26: prog = mk(OP_MUL, RG_A2, RG_E, RG_T);
            6'd27: prog = mk(OP_ADD, RG_RV, RG_T, RG_RV);
            6'd28: prog = mk(OP_MUL, RG_R2, RG_R, RG_T);
            6'd29: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd30: prog = mk(OP_ADD, RG_T, RG_T, RG_RP);
            6'd31: prog = mk(OP_MUL, RG_R, RG_A2, RG_T);
            6'd32: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd33: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd34: prog = mk(OP_ADD, RG_RP, RG_T, RG_RP);
            6'd35: prog = mk(OP_MUL, RG_R, RG_AB, RG_T);
            6'd36: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd37: prog = mk(OP_ADD, RG_T, RG_T, RG_T);
            6'd38: prog = mk(OP_SUB, RG_RP, RG_T, RG_RP);
            6'd39: prog = mk(OP_ADD, RG_U, RG_U, RG_T);
            6'd40: prog = mk(OP_SUB, RG_RP, RG_T, RG_RP);
            6'd41: prog = mk(OP_ADD, RG_E, RG_E, RG_T);
            6'd42: prog = mk(OP_ADD, RG_RP, RG_T, RG_RP);
            6'd43: prog = mk(OP_DIV, RG_RV, RG_RP, RG_STEP);
            default: prog = mk(OP_NONE, RG_ZERO, RG_ZERO, RG_ZERO);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        it_next     = it_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                    it_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (pc_reg == PC_W'(DERIV_END) && stat.rp_zero)
                begin
                    state_next  = ST_DONE;
                    status_next = STATUS_ZERO_DER;
                end
                else if (prog.op == OP_MUL || prog.op == OP_DIV)
                    state_next = ST_WAIT;
                else
                    pc_next = pc_reg + 1'b1;
            end
            ST_WAIT:
            begin
                if (wait_reg && !stat.busy)
                begin
                    if (pc_reg == PC_W'(PROG_LEN - 1))
                        state_next = ST_CHECK;
                    else
                    begin
                        state_next = ST_RUN;
                        pc_next    = pc_reg + 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                it_next = it_reg + 1'b1;
                if (stat.converged)
                begin
                    state_next  = ST_DONE;
                    status_next = STATUS_CONVERGED;
                end
                else if (it_reg == ITER_W'(MAX_ITERATIONS - 1))
                begin
                    state_next  = ST_DONE;
                    status_next = STATUS_CAP;
                end
                else
                begin
                    state_next = ST_RUN;
                    pc_next    = PC_W'(SETUP);
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = prog;
        cmd_valid = 1'b0;
        capture   = 1'b0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                capture   = in_valid;
                cmd       = mk(OP_NONE, RG_ZERO, RG_ZERO, RG_ZERO);
                cmd.load  = 1'b1;
                cmd_valid = in_valid;
            end
            ST_RUN:   cmd_valid = !(pc_reg == PC_W'(DERIV_END) && stat.rp_zero);
            ST_WAIT:  cmd_valid = 1'b0;
            ST_CHECK:
            begin
                cmd          = mk(OP_NONE, RG_ZERO, RG_ZERO, RG_ZERO);
                cmd.update_r = 1'b1;
                cmd_valid    = 1'b1;
            end
            ST_DONE:  out_valid = 1'b1;
            default:  cmd_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            it_reg     <= '0;
            status_reg <= STATUS_CONVERGED;
            wait_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            it_reg     <= it_next;
            status_reg <= status_next;
            wait_reg   <= (state_reg == ST_WAIT);
        end
    end

    assign status = status_reg;

    a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_DONE) else $error("result outside done");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall) else $error("accept while busy");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        it_reg <= ITER_W'(MAX_ITERATIONS)) else $error("iteration count overrun");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Kerr radial root finder. A predictor written in
// Q.24 saturating arithmetic works out the root and status of every accepted
// ray; results are compared in order. The bench runs directed corner cases,
// a sweep over spin and tolerance, physical and raw random rays, a drain
// pause and a final run with no idling.
// ----------------------------------------------------------------------------
module tb;
    import krrn_pkg::*;

    localparam logic signed [63:0] SAT62 = 64'sd1 <<< 62;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    krrn_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    krrn_out_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [25:0] cfg_data;

    logic signed [25:0] spin_reg;
    logic        [24:0] tol_reg;
    krrn_out_t          roots_due[$];
    int unsigned        fail_cnt;
    int unsigned        rays_sent;
    int unsigned        roots_seen;
    int unsigned        stall_left;
    bit                 idling_on;

    kerr_radial_root_newton dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] fx_clip(input logic signed [64:0] x);
        if (x > 65'sd1 <<< 62)
            return SAT62;
        if (x < -(65'sd1 <<< 62))
            return -SAT62;
        return x[63:0];
    endfunction

    function automatic logic signed [63:0] fx_add(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
        logic signed [64:0] s;
        s = 65'(fx_clip(65'(x))) + 65'(fx_clip(65'(y)));
        return fx_clip(s);
    endfunction

    function automatic logic [63:0] fx_abs(input logic signed [63:0] x);
        logic signed [63:0] c;
        c = fx_clip(65'(x));
        return (c < 0) ? -c : c;
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
        logic [127:0] p;
        logic [127:0] q;
        logic         neg;
        neg = (x < 0) != (y < 0);
        p = {64'd0, fx_abs(x)} * {64'd0, fx_abs(y)};
        q = p >> FRAC_BITS;
        if (neg && p[FRAC_BITS-1:0] != 0)
            q = q + 1;
        if (q > 128'(SAT62))
            q = 128'(SAT62);
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
        logic [127:0] q;
        logic         neg;
        neg = (n < 0) != (d < 0);
        q = ({64'd0, fx_abs(n)} << FRAC_BITS) / {64'd0, fx_abs(d)};
        if (q > 128'(SAT62))
            q = 128'(SAT62);
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic krrn_out_t solve_radial_root(input krrn_in_t ray);
        logic signed [63:0] a, b, qc, r, a2, ab, d, e;
        logic signed [63:0] r2, r3, r4, rv, rp, step, t;
        logic        [1:0]  st;
        krrn_out_t          res;
        a  = {{38{spin_reg[25]}}, spin_reg};
        b  = {{32{ray.impact_b[31]}}, ray.impact_b};
        qc = {{28{ray.carter_q[35]}}, ray.carter_q};
        r  = {33'd0, ray.start_radius};
        st = STATUS_CAP;
        if (r > RLIM)
            r = RLIM;
        a2 = fx_mul(a, a);
        ab = fx_mul(a, b);
        d  = fx_add(b, -a);
        e  = fx_add(fx_mul(d, d), qc);
        for (int it = 0; it < MAX_ITERATIONS; it++)
        begin
            r2 = fx_mul(r, r);
            r3 = fx_mul(r2, r);
            r4 = fx_mul(r2, r2);
            rv = r4;
            rv = fx_add(rv, fx_mul(a2, a2));
            rv = fx_add(rv, fx_mul(ab, ab));
            t = fx_mul(r2, a2); rv = fx_add(rv, fx_add(t, t));
            t = fx_mul(r2, ab); rv = fx_add(rv, -fx_add(t, t));
            t = fx_mul(a2, ab); rv = fx_add(rv, -fx_add(t, t));
            rv = fx_add(rv, -fx_mul(r2, e));
            t = fx_mul(r, e); rv = fx_add(rv, fx_add(t, t));
            rv = fx_add(rv, fx_mul(a2, e));
            t = fx_add(r3, r3); rp = fx_add(t, t);
            t = fx_mul(r, a2); t = fx_add(t, t); rp = fx_add(rp, fx_add(t, t));
            t = fx_mul(r, ab); t = fx_add(t, t); rp = fx_add(rp, -fx_add(t, t));
            t = fx_mul(r, e); rp = fx_add(rp, -fx_add(t, t));
            rp = fx_add(rp, fx_add(e, e));
            if (rp == 0)
            begin
                st = STATUS_ZERO_DER;
                break;
            end
            step = fx_div(rv, rp);
            r = r - step;
            if (r > RLIM)
                r = RLIM;
            if (r < -RLIM)
                r = -RLIM;
            if (fx_abs(step) <= {39'd0, tol_reg})
            begin
                st = STATUS_CONVERGED;
                break;
            end
        end
        res.root_radius = r[31:0];
        res.status      = st;
        return res;
    endfunction

    // result side
    always @(posedge clk)
    begin
        krrn_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            roots_seen++;
            if (roots_due.size() == 0)
            begin
                $error("unexpected result transfer: root_radius %0d status %0d",
                       out_data.root_radius, out_data.status);
                fail_cnt++;
            end
            else
            begin
                want = roots_due.pop_front();
                if (out_data.root_radius !== want.root_radius)
                begin
                    $error("root_radius: expected %0d, actual %0d",
                           want.root_radius, out_data.root_radius);
                    fail_cnt++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status,
                           out_data.status);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_ray(input logic [31:0] b, input logic [35:0] q,
                            input logic [30:0] r);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_data.impact_b      <= b;
        in_data.carter_q      <= q;
        in_data.start_radius  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        roots_due.push_back(solve_radial_root(in_data));
        rays_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (roots_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [25:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_SPIN)
            spin_reg = val;
        else
            tol_reg = val[24:0];
        cfg_we <= 1'b0;
    endtask

    task automatic send_physical_ray();
        int signed   b;
        int signed   q;
        b = int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
        q = int'($urandom_range(0, 32'h2000_0000)) - 32'sh0200_0000;
        send_ray(b, 36'(q), 31'($urandom_range(32'h0100_0000, 32'h3000_0000)));
    endtask

    task automatic send_raw_ray();
        logic [63:0] w;
        w = {$urandom, $urandom};
        send_ray(w[31:0], {w[63:60], $urandom}, 31'($urandom));
    endtask

    task automatic test_corners();
        send_ray(32'd0, 36'd0, 31'd0);
        send_ray(32'sh4000_0000, 36'sh4_0000_0000, 31'h4000_0000);
        send_ray(-32'sh4000_0000, -36'sh4_0000_0000, 31'h4000_0000);
        send_ray(32'h8000_0000, 36'h8_0000_0000, 31'h7fff_ffff);
        send_ray(32'h7fff_ffff, 36'h7_ffff_ffff, 31'h7fff_ffff);
        send_ray(32'h0200_0000, 36'h0_0400_0000, 31'h0a00_0000);
        send_ray(32'h0300_0000, 36'h0_1000_0000, 31'h0000_0001);
        send_ray(32'hfd00_0000, 36'hf_f000_0000, 31'h1400_0000);
        write_reg(CFG_SPIN, 26'h100_0000);
        send_ray(32'h0100_0000, 36'd0, 31'd0);
        send_ray(32'h0500_0000, 36'h0_0800_0000, 31'h0600_0000);
        write_reg(CFG_SPIN, 26'h300_0000);
        send_ray(32'hfb00_0000, 36'h0_1400_0000, 31'h0800_0000);
        send_ray(32'h8000_0000, 36'h7_ffff_ffff, 31'h0);
        // exact-zero convergence only
        write_reg(CFG_TOLERANCE, 26'd0);
        send_ray(32'h0400_0000, 36'h0_0c00_0000, 31'h1000_0000);
        send_ray(32'd0, 36'd0, 31'h0200_0000);
        write_reg(CFG_TOLERANCE, 26'h1ff_ffff);
        send_ray(32'h0400_0000, 36'h0_0c00_0000, 31'h1000_0000);
        write_reg(CFG_SPIN, 26'd0);
        write_reg(CFG_TOLERANCE, 26'd1677);
    endtask

    task automatic test_config_sweep();
        logic [25:0] spins[6];
        logic [25:0] tols[4];
        spins = '{26'h100_0000, 26'h300_0000, 26'h200_0000, 26'h1ff_ffff,
                  26'h0, 26'h0c0_0000};
        tols  = '{26'd1, 26'h100_0000, 26'h1ff_ffff, 26'd1677};
        foreach (spins[i])
        begin
            write_reg(CFG_SPIN, spins[i]);
            write_reg(CFG_TOLERANCE, tols[i % 4]);
            repeat (12) send_physical_ray();
            repeat (3) send_raw_ray();
        end
        repeat (6)
        begin
            write_reg(CFG_SPIN, 26'($urandom));
            write_reg(CFG_TOLERANCE, 26'($urandom));
            repeat (6) send_physical_ray();
        end
        write_reg(CFG_SPIN, 26'h0b3_3333);
        write_reg(CFG_TOLERANCE, 26'd1677);
    endtask

    task automatic test_physical_rays();
        repeat (520)
            send_physical_ray();
    endtask

    task automatic test_raw_rays();
        repeat (180)
            send_raw_ray();
    endtask

    task automatic test_drain_pause();
        repeat (3)
        begin
            repeat (10) send_physical_ray();
            wait_drained();
        end
    endtask

    task automatic test_no_idling();
        wait_drained();
        idling_on = 1'b0;
        repeat (60) send_physical_ray();
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SPIN;
        cfg_data   = '0;
        spin_reg   = '0;
        tol_reg    = 25'd1677;
        fail_cnt   = 0;
        rays_sent  = 0;
        roots_seen = 0;
        idling_on  = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_config_sweep();
        test_physical_rays();
        test_raw_rays();
        test_drain_pause();
        test_no_idling();
        $display("%0d rays sent, %0d roots checked over corner, spin/tolerance,",
                 rays_sent, roots_seen);
        $display("physical, raw and unthrottled runs");
        if (fail_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #1_000_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
